/* design/svm_pkg.sv */
// package with opcodes and register indexes of the stack machine execute unit
package svm_pkg;

    localparam logic [7:0] OP_PUSH  = 8'd0;
    localparam logic [7:0] OP_ADD   = 8'd1;
    localparam logic [7:0] OP_POP   = 8'd2;
    localparam logic [7:0] OP_HALT  = 8'd3;
    localparam logic [7:0] OP_SET   = 8'd4;
    localparam logic [7:0] OP_EQ    = 8'd5;
    localparam logic [7:0] OP_DEC   = 8'd6;
    localparam logic [7:0] OP_BRK   = 8'd7;
    localparam logic [7:0] OP_NOP   = 8'd8;
    localparam logic [7:0] OP_PRINT = 8'd9;

    localparam logic [2:0] REG_IP = 3'd6;
    localparam logic [2:0] REG_SP = 3'd7;

    typedef logic [31:0] t_word;

endpackage

/* design/stack_vm_execute_unit.sv */
// stack machine execute unit: register file, word stack and one-pass instruction execution
//
// Input channel (i_in_valid / o_in_ready) takes one instruction per transfer: the opcode
// and the three program bytes after it. Output channel (o_out_valid / i_out_ready) gives
// one result per instruction, in order: next instruction address, halt status, popped
// value and print offset.
// An instruction is held in the input register and executes as it moves into the output
// register, which holds its result for the receiver. One instruction per cycle is
// sustained while the receiver takes results; the stack is a memory with one write and
// two read ports whose registered read data is refreshed every cycle at the new top and
// second entries. After reset the stack is swept to zero, one entry a cycle, while
// o_in_ready stays low. Registers, stack pointer and halt flag reset to zero.
// When the receiver stalls, the result is held in the output register and one more
// instruction can wait in the input register; o_in_ready then drops.
// After a halt, every later instruction returns the same address with halted set and
// changes nothing.
module stack_vm_execute_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_op,
    input  logic [7:0]         i_arg_first,
    input  logic [7:0]         i_arg_second,
    input  logic [7:0]         i_arg_third,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_next_address,
    output logic               o_halted,
    output logic               o_pop_valid,
    output logic signed [31:0] o_pop_value,
    output logic               o_print_valid,
    output logic [7:0]         o_print_offset
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(STACK_DEPTH - 1);
    // slot of the stack pointer value all ones
    localparam logic [SW-1:0] WRAP_SLOT = SW'(64'hFFFF_FFFF % STACK_DEPTH);

    // slot after the stack pointer moves up by one
    function automatic logic [SW-1:0] f_slot_inc(input svm_pkg::t_word sp,
                                                 input logic [SW-1:0] slot);
        logic [SW-1:0] res;
        if (sp == 32'hFFFF_FFFF) begin
            res = '0;
        end else if (slot == LAST_SLOT) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

    // slot after the stack pointer moves down by one
    function automatic logic [SW-1:0] f_slot_dec(input svm_pkg::t_word sp,
                                                 input logic [SW-1:0] slot);
        logic [SW-1:0] res;
        if (sp == 32'd0) begin
            res = WRAP_SLOT;
        end else if (slot == '0) begin
            res = LAST_SLOT;
        end else begin
            res = slot - 1'b1;
        end
        return res;
    endfunction

    // slot of a byte written straight into the stack pointer
    logic [SW-1:0] w_set_slot [256];
    for (genvar g = 0; g < 256; g++) begin : g_set_slot
        assign w_set_slot[g] = SW'(g % STACK_DEPTH);
    end

    // input register
    logic          r_in_valid;
    logic [7:0]    r_op;
    logic [7:0]    r_arg_first;
    logic [7:0]    r_arg_second;
    logic [7:0]    r_arg_third;

    // architectural state
    svm_pkg::t_word r_regs [8];
    svm_pkg::t_word n_regs [8];
    logic [SW-1:0]  r_slot;
    logic [SW-1:0]  n_slot;
    logic           r_stopped;
    logic           n_stopped;

    // stack memory and its registered read data
    svm_pkg::t_word r_stack [STACK_DEPTH];
    svm_pkg::t_word r_top;
    svm_pkg::t_word r_sec;
    logic           r_clr_busy;
    logic [SW-1:0]  r_clr_idx;

    // execute results
    logic           w_move;
    logic           w_exec_we;
    svm_pkg::t_word w_exec_wdata;
    logic           w_pop_valid;
    svm_pkg::t_word w_pop_value;
    logic           w_print_valid;
    logic [7:0]     w_print_offset;
    logic           w_we;
    logic [SW-1:0]  w_waddr;
    svm_pkg::t_word w_wdata;
    logic [SW-1:0]  w_rd_top;
    logic [SW-1:0]  w_rd_sec;

    // output register
    logic           r_out_valid;
    svm_pkg::t_word r_next_address;
    logic           r_halted;
    logic           r_pop_valid;
    svm_pkg::t_word r_pop_value;
    logic           r_print_valid;
    logic [7:0]     r_print_offset;

    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_in_valid || w_move);

    always_comb begin
        logic [2:0]    idx_a;
        logic [2:0]    idx_b;
        logic [SW-1:0] sec_slot;
        idx_a          = r_arg_first[2:0];
        idx_b          = r_arg_second[2:0];
        sec_slot       = f_slot_dec(r_regs[svm_pkg::REG_SP], r_slot);
        n_regs         = r_regs;
        n_slot         = r_slot;
        n_stopped      = r_stopped;
        w_exec_we      = 1'b0;
        w_exec_wdata   = r_top + r_sec;
        w_pop_valid    = 1'b0;
        w_pop_value    = '0;
        w_print_valid  = 1'b0;
        w_print_offset = '0;
        if (!r_stopped) begin
            case (r_op)
                svm_pkg::OP_PUSH: begin
                    n_regs[svm_pkg::REG_SP] = r_regs[svm_pkg::REG_SP] + 32'd1;
                    n_slot                  = f_slot_inc(r_regs[svm_pkg::REG_SP], r_slot);
                    n_regs[svm_pkg::REG_IP] = r_regs[svm_pkg::REG_IP] + 32'd1;
                    w_exec_we               = 1'b1;
                    w_exec_wdata            = 32'(r_arg_first);
                end
                svm_pkg::OP_ADD: begin
                    n_regs[svm_pkg::REG_SP] = r_regs[svm_pkg::REG_SP] - 32'd1;
                    n_slot                  = sec_slot;
                    w_exec_we               = 1'b1;
                end
                svm_pkg::OP_POP: begin
                    w_pop_valid             = 1'b1;
                    w_pop_value             = r_top;
                    n_regs[svm_pkg::REG_SP] = r_regs[svm_pkg::REG_SP] - 32'd1;
                    n_slot                  = sec_slot;
                end
                svm_pkg::OP_HALT: begin
                    n_stopped = 1'b1;
                end
                svm_pkg::OP_SET: begin
                    n_regs[svm_pkg::REG_IP] = r_regs[svm_pkg::REG_IP] + 32'd2;
                    n_regs[idx_a]           = 32'(r_arg_second);
                    if (idx_a == svm_pkg::REG_SP) begin
                        n_slot = w_set_slot[r_arg_second];
                    end
                end
                svm_pkg::OP_EQ: begin
                    // the compare sees the pointer already advanced by three, at the third operand
                    n_regs[svm_pkg::REG_IP] = r_regs[svm_pkg::REG_IP] + 32'd3;
                    if (n_regs[idx_a] == n_regs[idx_b]) begin
                        n_regs[svm_pkg::REG_IP] = 32'(r_arg_third);
                    end
                end
                svm_pkg::OP_DEC: begin
                    n_regs[svm_pkg::REG_IP] = r_regs[svm_pkg::REG_IP] + 32'd1;
                    if (idx_a == svm_pkg::REG_SP) begin
                        n_slot = sec_slot;
                    end
                    n_regs[idx_a] = n_regs[idx_a] - 32'd1;
                end
                svm_pkg::OP_PRINT: begin
                    n_regs[svm_pkg::REG_IP] = r_regs[svm_pkg::REG_IP] + 32'd1;
                    w_print_valid           = 1'b1;
                    w_print_offset          = r_arg_first;
                end
                default: begin
                end
            endcase
            n_regs[svm_pkg::REG_IP] = n_regs[svm_pkg::REG_IP] + 32'd1;
        end
    end

    // push and add both write the new top slot; during the reset sweep the port zeroes the swept entry
    always_comb begin
        if (r_clr_busy) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '0;
        end else begin
            w_we    = w_move && w_exec_we;
            w_waddr = n_slot;
            w_wdata = w_exec_wdata;
        end
    end

    // read addresses follow the stack pointer as it stands after this edge
    always_comb begin
        if (w_move) begin
            w_rd_top = n_slot;
            w_rd_sec = f_slot_dec(n_regs[svm_pkg::REG_SP], n_slot);
        end else begin
            w_rd_top = r_slot;
            w_rd_sec = f_slot_dec(r_regs[svm_pkg::REG_SP], r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        if (w_we && (w_waddr == w_rd_top)) begin
            r_top <= w_wdata;
        end else begin
            r_top <= r_stack[w_rd_top];
        end
        if (w_we && (w_waddr == w_rd_sec)) begin
            r_sec <= w_wdata;
        end else begin
            r_sec <= r_stack[w_rd_sec];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == LAST_SLOT) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= '0;
            end
            r_slot    <= '0;
            r_stopped <= 1'b0;
        end else if (w_move) begin
            r_regs    <= n_regs;
            r_slot    <= n_slot;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op         <= i_op;
            r_arg_first  <= i_arg_first;
            r_arg_second <= i_arg_second;
            r_arg_third  <= i_arg_third;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_next_address <= n_regs[svm_pkg::REG_IP];
            r_halted       <= n_stopped;
            r_pop_valid    <= w_pop_valid;
            r_pop_value    <= w_pop_value;
            r_print_valid  <= w_print_valid;
            r_print_offset <= w_print_offset;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_address = r_next_address;
    assign o_halted       = r_halted;
    assign o_pop_valid    = r_pop_valid;
    assign o_pop_value    = r_pop_value;
    assign o_print_valid  = r_print_valid;
    assign o_print_offset = r_print_offset;

endmodule

/* design/svm_checker.sv */
// port checker for the stack machine execute unit, with its bind
module svm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_next_address,
    input logic               o_halted,
    input logic               o_pop_valid,
    input logic signed [31:0] o_pop_value,
    input logic               o_print_valid,
    input logic [7:0]         o_print_offset
);

    logic               r_seen_halt;
    logic signed [31:0] r_halt_addr;

    // remember the address reported with the first halted result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
            r_halt_addr <= '0;
        end else if (o_out_valid && i_out_ready && o_halted && !r_seen_halt) begin
            r_seen_halt <= 1'b1;
            r_halt_addr <= o_next_address;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_halt |->
            o_halted && (o_next_address == r_halt_addr) && !o_pop_valid && !o_print_valid)
        else $error("result after halt changed state or lost halt");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_pop_valid && o_print_valid))
        else $error("pop and print in one result");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pop_valid || (o_pop_value == 0))
                     && (o_print_valid || (o_print_offset == 8'd0)))
        else $error("unused result field not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_next_address))
        else $error("stalled result dropped or changed");

endmodule

bind stack_vm_execute_unit svm_checker u_svm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_next_address (o_next_address),
    .o_halted       (o_halted),
    .o_pop_valid    (o_pop_valid),
    .o_pop_value    (o_pop_value),
    .o_print_valid  (o_print_valid),
    .o_print_offset (o_print_offset)
);
